// ===== rtl/core/bcd_pkg.sv =====
// Shared types, constants and helper functions for the BC1/BC3 block decoder.
`timescale 1ns / 1ps
package bcd_pkg;

   localparam int MAX_DIM = 16384;
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // register indexes on the csr port
   localparam logic [1:0] REG_FORMAT = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   typedef struct packed {
      logic [63:0] alpha_word;
      logic [63:0] color_word;
   } bcd_req_type;

   typedef struct packed {
      logic [13:0] pixel_x;
      logic [13:0] pixel_y;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic        block_done;
      logic        image_done;
   } bcd_rsp_type;

   typedef struct packed {
      logic        dxt5;
      logic [14:0] width;
      logic [14:0] height;
   } bcd_cfg_type;

   // one decoded block: palettes plus placement, as queued between front and back
   typedef struct packed {
      logic [13:0]          x0;
      logic [13:0]          y0;
      logic [1:0]           ncols_m1;
      logic [1:0]           nrows_m1;
      logic                 last_block;
      logic                 dxt5;
      logic [31:0]          cidx;
      logic [47:0]          aidx;
      logic [3:0][3:0][7:0] cpal;   // [entry][r,g,b,a]
      logic [7:0][7:0]      apal;
   } bcd_blk_type;

   // 565 channel expansion tables, built at elaboration
   function automatic logic [31:0][7:0] exp5_table();
      logic [31:0][7:0] t;
      for (int i = 0; i < 32; i++) begin
         t[i] = 8'((i * 255 + 15) / 31);
      end
      return t;
   endfunction

   function automatic logic [63:0][7:0] exp6_table();
      logic [63:0][7:0] t;
      for (int i = 0; i < 64; i++) begin
         t[i] = 8'((i * 255 + 31) / 63);
      end
      return t;
   endfunction

   localparam logic [31:0][7:0] EXP5 = exp5_table();
   localparam logic [63:0][7:0] EXP6 = exp6_table();

   // reciprocal dividers, exact over the operand ranges used here
   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [19:0] p;
      p = 20'(x) * 20'd683;
      return p[18:11];
   endfunction

   function automatic logic [7:0] div5(input logic [10:0] x);
      logic [20:0] p;
      p = 21'(x) * 21'd1639;
      return p[20:13];
   endfunction

   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [22:0] p;
      p = 23'(x) * 23'd2341;
      return p[21:14];
   endfunction

endpackage

// ===== rtl/core/bc1_bc3_block_decoder_unit.sv =====
// Top level of the BC1/BC3 texture block decoder: csr registers, credit control, front/queue/back.
// Path: decode stage register, then block queue, then the pixel result register.
// Throughput: one pixel transaction per cycle unless the result side stalls; a block gives
// 1 to 16 pixels in the back end, one per in-image pixel, and the pixel walk is the pacing unit.
// Up to 4 blocks may be in flight (decode stage plus 4-entry queue) before full rises.
// Reset: synchronous, active high; format 0 (DXT1), width and height 1, block position 0.
`timescale 1ns / 1ps
module bc1_bc3_block_decoder_unit import bcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // input blocks
   input  logic        req_push,
   output logic        req_full,
   input  bcd_req_type req_data,
   // decoded pixels
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output bcd_rsp_type rsp_data,
   // csr port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic              fmt_ff, fmt_in;
   logic [14:0]       width_ff, width_in, height_ff, height_in;
   logic [QCNT_W-1:0] credit_ff, credit_in;

   logic        csr_wr, cfg_clear, accept;
   logic [1:0]  csr_idx;
   bcd_cfg_type cfg;

   logic        blk_valid, head_valid, head_pop;
   bcd_blk_type blk_data, head_data;

   // csr access: every transaction completes in its access cycle
   always_comb begin
      csr_pready = 1'b1;
      csr_idx    = csr_paddr[3:2];
      csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

      fmt_in    = fmt_ff;
      width_in  = width_ff;
      height_in = height_ff;
      cfg_clear = 1'b0;
      case (csr_idx)
         REG_FORMAT: begin
            if (csr_wr) begin
               fmt_in    = csr_pwdata[0];
               cfg_clear = 1'b1;
            end
            csr_prdata = {31'd0, fmt_ff};
         end
         REG_WIDTH: begin
            if (csr_wr) begin
               width_in  = csr_pwdata[14:0];
               cfg_clear = 1'b1;
            end
            csr_prdata = {17'd0, width_ff};
         end
         REG_HEIGHT: begin
            if (csr_wr) begin
               height_in = csr_pwdata[14:0];
               cfg_clear = 1'b1;
            end
            csr_prdata = {17'd0, height_ff};
         end
         default: begin
            csr_prdata = 32'd0;
         end
      endcase

      cfg.dxt5   = fmt_ff;
      cfg.width  = width_ff;
      cfg.height = height_ff;
   end

   // credits cover the decode stage and the queue, so the front never stalls
   always_comb begin
      req_full  = (credit_ff == QCNT_W'(QDEPTH));
      accept    = req_push && !req_full;
      credit_in = credit_ff + QCNT_W'(accept) - QCNT_W'(head_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= 1'b0;
         width_ff  <= 15'd1;
         height_ff <= 15'd1;
         credit_ff <= '0;
      end else begin
         fmt_ff    <= fmt_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         credit_ff <= credit_in;
      end
   end

   bcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cfg_clear (cfg_clear),
      .accept    (accept),
      .req_data  (req_data),
      .blk_valid (blk_valid),
      .blk_data  (blk_data)
   );

   bcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (blk_valid),
      .push_data  (blk_data),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   bcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .head_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      credit_ff <= QCNT_W'(QDEPTH))
      else $error("block credit count out of range");

   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.image_done) |-> rsp_data.block_done)
      else $error("image end flagged off a block end");

endmodule

// ===== rtl/core/bcd_front.sv =====
// Front end: block placement, endpoint expansion and palette build into the block queue.
`timescale 1ns / 1ps
module bcd_front import bcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  bcd_cfg_type cfg,
   input  logic        cfg_clear,
   input  logic        accept,
   input  bcd_req_type req_data,
   output logic        blk_valid,
   output bcd_blk_type blk_data
);

   typedef struct packed {
      logic [13:0]          x0;
      logic [13:0]          y0;
      logic [1:0]           ncols_m1;
      logic [1:0]           nrows_m1;
      logic                 last_block;
      logic                 dxt5;
      logic                 four;
      logic [31:0]          cidx;
      logic [47:0]          aidx;
      logic [2:0][7:0]      e0;
      logic [2:0][7:0]      e1;
      logic [2:0][9:0]      s21;
      logic [2:0][9:0]      s12;
      logic [2:0][8:0]      smid;
      logic [7:0]           a0;
      logic [7:0]           a1;
      logic                 agt;
      logic [5:0][10:0]     sev;
      logic [3:0][10:0]     fif;
   } bcd_s1_type;

   logic [11:0] col_ff, col_in, row_ff, row_in;
   logic        s1_valid_ff;
   bcd_s1_type  s1_ff, s1_in;

   logic [14:0] wc, hc, rem_x, rem_y;
   logic [12:0] bw, bh, col_inc, row_inc;
   logic [11:0] col_cur, row_cur;
   logic        pos_ok, col_wrap, row_wrap;
   logic [15:0] c0, c1;

   always_comb begin
      wc = (cfg.width == 15'd0) ? 15'd1 :
           (cfg.width > 15'(MAX_DIM)) ? 15'(MAX_DIM) : cfg.width;
      hc = (cfg.height == 15'd0) ? 15'd1 :
           (cfg.height > 15'(MAX_DIM)) ? 15'(MAX_DIM) : cfg.height;
      bw = 13'((wc + 15'd3) >> 2);
      bh = 13'((hc + 15'd3) >> 2);
      pos_ok  = ({1'b0, col_ff} < bw) && ({1'b0, row_ff} < bh);
      col_cur = pos_ok ? col_ff : 12'd0;
      row_cur = pos_ok ? row_ff : 12'd0;
      col_inc = {1'b0, col_cur} + 13'd1;
      row_inc = {1'b0, row_cur} + 13'd1;
      col_wrap = (col_inc == bw);
      row_wrap = (row_inc == bh);

      col_in = col_ff;
      row_in = row_ff;
      if (cfg_clear) begin
         col_in = 12'd0;
         row_in = 12'd0;
      end else if (accept) begin
         col_in = col_wrap ? 12'd0 : col_inc[11:0];
         row_in = col_wrap ? (row_wrap ? 12'd0 : row_inc[11:0]) : row_cur;
      end

      c0 = req_data.color_word[15:0];
      c1 = req_data.color_word[31:16];

      s1_in.x0 = {col_cur, 2'b00};
      s1_in.y0 = {row_cur, 2'b00};
      rem_x = wc - {1'b0, s1_in.x0};
      rem_y = hc - {1'b0, s1_in.y0};
      s1_in.ncols_m1 = (rem_x > 15'd3) ? 2'd3 : 2'(rem_x - 15'd1);
      s1_in.nrows_m1 = (rem_y > 15'd3) ? 2'd3 : 2'(rem_y - 15'd1);
      s1_in.last_block = col_wrap && row_wrap;
      s1_in.dxt5 = cfg.dxt5;
      s1_in.four = cfg.dxt5 || (c0 > c1);
      s1_in.cidx = req_data.color_word[63:32];
      s1_in.aidx = req_data.alpha_word[63:16];
      s1_in.e0[0] = EXP5[c0[15:11]];
      s1_in.e0[1] = EXP6[c0[10:5]];
      s1_in.e0[2] = EXP5[c0[4:0]];
      s1_in.e1[0] = EXP5[c1[15:11]];
      s1_in.e1[1] = EXP6[c1[10:5]];
      s1_in.e1[2] = EXP5[c1[4:0]];
      for (int k = 0; k < 3; k++) begin
         s1_in.s21[k]  = {1'b0, s1_in.e0[k], 1'b0} + 10'(s1_in.e1[k]);
         s1_in.s12[k]  = 10'(s1_in.e0[k]) + {1'b0, s1_in.e1[k], 1'b0};
         s1_in.smid[k] = 9'(s1_in.e0[k]) + 9'(s1_in.e1[k]);
      end
      s1_in.a0  = req_data.alpha_word[7:0];
      s1_in.a1  = req_data.alpha_word[15:8];
      s1_in.agt = s1_in.a0 > s1_in.a1;
      for (int i = 1; i <= 6; i++) begin
         s1_in.sev[i-1] = 11'(7 - i) * 11'(s1_in.a0) + 11'(i) * 11'(s1_in.a1);
      end
      // weighted sums reach 5 * 255, so they need eleven bits
      for (int i = 1; i <= 4; i++) begin
         s1_in.fif[i-1] = 11'(5 - i) * 11'(s1_in.a0) + 11'(i) * 11'(s1_in.a1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= 12'd0;
         row_ff      <= 12'd0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // second step: divides by 3, 5 and 7, palette select
   always_comb begin
      blk_valid           = s1_valid_ff;
      blk_data.x0         = s1_ff.x0;
      blk_data.y0         = s1_ff.y0;
      blk_data.ncols_m1   = s1_ff.ncols_m1;
      blk_data.nrows_m1   = s1_ff.nrows_m1;
      blk_data.last_block = s1_ff.last_block;
      blk_data.dxt5       = s1_ff.dxt5;
      blk_data.cidx       = s1_ff.cidx;
      blk_data.aidx       = s1_ff.aidx;
      for (int k = 0; k < 3; k++) begin
         blk_data.cpal[0][k] = s1_ff.e0[k];
         blk_data.cpal[1][k] = s1_ff.e1[k];
         blk_data.cpal[2][k] = s1_ff.four ? div3(s1_ff.s21[k]) : s1_ff.smid[k][8:1];
         blk_data.cpal[3][k] = s1_ff.four ? div3(s1_ff.s12[k]) : 8'd0;
      end
      blk_data.cpal[0][3] = 8'd255;
      blk_data.cpal[1][3] = 8'd255;
      blk_data.cpal[2][3] = 8'd255;
      blk_data.cpal[3][3] = s1_ff.four ? 8'd255 : 8'd0;
      blk_data.apal[0] = s1_ff.a0;
      blk_data.apal[1] = s1_ff.a1;
      if (s1_ff.agt) begin
         for (int i = 0; i < 6; i++) begin
            blk_data.apal[i+2] = div7(s1_ff.sev[i]);
         end
      end else begin
         for (int i = 0; i < 4; i++) begin
            blk_data.apal[i+2] = div5(s1_ff.fif[i]);
         end
         blk_data.apal[6] = 8'd0;
         blk_data.apal[7] = 8'd255;
      end
   end

   // the four-color palette must be forced in DXT5 mode
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.dxt5) |-> s1_ff.four)
      else $error("dxt5 block decoded with three-color palette");

endmodule

// ===== rtl/core/bcd_queue.sv =====
// Small block queue between the decode front and the pixel back end.
`timescale 1ns / 1ps
module bcd_queue import bcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   input  bcd_blk_type push_data,
   input  logic        pop,
   output logic        head_valid,
   output bcd_blk_type head_data
);

   bcd_blk_type           entry_ff [QDEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push_valid) - QCNT_W'(pop);
      head_valid = (count_ff != '0);
      head_data  = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (count_ff != QCNT_W'(QDEPTH) || pop))
      else $error("block queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("block queue underflow");

endmodule

// ===== rtl/core/bcd_back.sv =====
// Back end: visible head-block pixels go into the result register, one per cycle unless stalled.
`timescale 1ns / 1ps
module bcd_back import bcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  bcd_blk_type head_data,
   output logic        head_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output bcd_rsp_type rsp_data
);

   logic [1:0]  px_ff, px_in, py_ff, py_in;
   logic        out_valid_ff, out_valid_in;
   bcd_rsp_type out_ff, out_in;

   logic        adv, last_col, last_row, blk_end;
   logic [3:0]  pix;
   logic [1:0]  cc;
   logic [2:0]  ai;

   always_comb begin
      adv      = head_valid && (!out_valid_ff || rsp_pop);
      last_col = (px_ff == head_data.ncols_m1);
      last_row = (py_ff == head_data.nrows_m1);
      blk_end  = last_col && last_row;
      head_pop = adv && blk_end;

      pix = {py_ff, px_ff};
      cc  = head_data.cidx[{pix, 1'b0} +: 2];
      ai  = head_data.aidx[6'(pix) * 6'd3 +: 3];

      out_in.pixel_x    = {head_data.x0[13:2], px_ff};
      out_in.pixel_y    = {head_data.y0[13:2], py_ff};
      out_in.red        = head_data.cpal[cc][0];
      out_in.green      = head_data.cpal[cc][1];
      out_in.blue       = head_data.cpal[cc][2];
      out_in.alpha      = head_data.dxt5 ? head_data.apal[ai] : head_data.cpal[cc][3];
      out_in.block_done = blk_end;
      out_in.image_done = blk_end && head_data.last_block;

      px_in = px_ff;
      py_in = py_ff;
      if (adv) begin
         px_in = last_col ? 2'd0 : px_ff + 2'd1;
         py_in = last_col ? (last_row ? 2'd0 : py_ff + 2'd1) : py_ff;
      end

      out_valid_in = adv ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);

      rsp_empty = !out_valid_ff;
      rsp_data  = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff        <= 2'd0;
         py_ff        <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         px_ff        <= px_in;
         py_ff        <= py_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   // the pixel walk must restart at the block corner when a block retires
   assert property (@(posedge clock) disable iff (reset)
      head_pop |=> (px_ff == 2'd0 && py_ff == 2'd0))
      else $error("pixel walk not restarted after block end");

endmodule

// ===== verif/bc1_bc3_block_decoder_unit_test.sv =====
// Self-checking testbench for the BC1/BC3 block decoder: directed table, random phases, pixel scoreboard.
`timescale 1ns / 1ps
module bc1_bc3_block_decoder_unit_test;
   import bcd_pkg::*;

   // Test plan
   //  - directed table first: the 1x1 image after reset gives exactly one pixel per block,
   //    so those rows carry their expected pixel typed in (endpoint extremes, thirds, midpoint,
   //    transparent black, DXT5 sevenths and the 0/255 alpha entries)
   //  - remaining directed rows exercise zero and oversize dimensions, partial edge blocks,
   //    image wrap, a write past the last register and a mode change in mid-image
   //  - random phases: new settings per phase (sometimes kept, so the block position carries
   //    over), random blocks biased toward equal/ordered endpoints
   //  - one phase holds the pixel side off for a long stretch so the block queue fills and
   //    raises full while blocks keep being offered
   // Every accepted block runs through decode_block; each popped pixel is checked against
   // the oldest entry of pending_pixels.

   localparam int          TOTAL_BLOCKS = 310;
   localparam int          DRAIN_CYCLES = 8;     // margin above the first-pixel latency
   localparam int          QUIET_LIMIT  = 2000;  // well above the long receiver hold
   localparam int          LONG_HOLD    = 250;
   localparam logic [1:0]  REG_SPARE    = 2'd3;  // no register behind this index

   typedef enum logic {ROW_BLOCK, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [1:0]   reg_idx;
      logic [31:0]  reg_val;
      bcd_req_type  blk;
      bit           typed;
      bcd_rsp_type  pixel;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   bcd_req_type req_data = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   bcd_rsp_type rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor copy of the registers and the block position
   bit          cfg_dxt5;
   logic [14:0] cfg_width = 15'd1;
   logic [14:0] cfg_height = 15'd1;
   int unsigned blk_col;
   int unsigned blk_row;

   bcd_rsp_type  block_pixels[$];    // pixels of the block just decoded
   bcd_rsp_type  pending_pixels[$];  // expected pixels not yet popped
   stim_row_type directed_rows[$];

   bit          idle_on = 1'b1;     // random gaps on both sides when set
   int unsigned long_hold;          // one-shot long stall request for the pixel side
   int unsigned mismatch_count;
   int unsigned blocks_sent;
   int unsigned pixels_checked;
   int unsigned images_seen;
   int unsigned reg_writes;

   bc1_bc3_block_decoder_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned clip_dim(input logic [14:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   function automatic int unsigned widen5(input int unsigned v);
      return (v * 255 + 15) / 31;
   endfunction

   function automatic int unsigned widen6(input int unsigned v);
      return (v * 255 + 31) / 63;
   endfunction

   // decodes one block at the current position into block_pixels and steps the position
   function automatic void decode_block(input bcd_req_type blk);
      int unsigned w, h, bw, bh, x, y, loc, cc, av;
      int unsigned e0[3], e1[3], cpal[4][4], apal[8];
      int unsigned a0, a1;
      logic [15:0] c0, c1;
      logic [31:0] cidx;
      logic [47:0] aidx;
      bit          four, last_blk;
      bcd_rsp_type pix;

      block_pixels.delete();
      w = clip_dim(cfg_width);
      h = clip_dim(cfg_height);
      bw = (w + 3) / 4;
      bh = (h + 3) / 4;
      if (blk_col >= bw || blk_row >= bh) begin
         blk_col = 0;
         blk_row = 0;
      end
      last_blk = (blk_col + 1 == bw) && (blk_row + 1 == bh);

      c0 = blk.color_word[15:0];
      c1 = blk.color_word[31:16];
      cidx = blk.color_word[63:32];
      e0[0] = widen5(c0[15:11]);
      e0[1] = widen6(c0[10:5]);
      e0[2] = widen5(c0[4:0]);
      e1[0] = widen5(c1[15:11]);
      e1[1] = widen6(c1[10:5]);
      e1[2] = widen5(c1[4:0]);
      // DXT5 color half always runs in four-color mode
      four = cfg_dxt5 || (c0 > c1);
      for (int k = 0; k < 3; k++) begin
         cpal[0][k] = e0[k];
         cpal[1][k] = e1[k];
         if (four) begin
            cpal[2][k] = (2 * e0[k] + e1[k]) / 3;
            cpal[3][k] = (e0[k] + 2 * e1[k]) / 3;
         end else begin
            cpal[2][k] = (e0[k] + e1[k]) / 2;
            cpal[3][k] = 0;
         end
      end
      cpal[0][3] = 255;
      cpal[1][3] = 255;
      cpal[2][3] = 255;
      cpal[3][3] = four ? 255 : 0;

      a0 = blk.alpha_word[7:0];
      a1 = blk.alpha_word[15:8];
      aidx = blk.alpha_word[63:16];
      apal[0] = a0;
      apal[1] = a1;
      if (a0 > a1) begin
         for (int i = 1; i <= 6; i++) apal[i + 1] = ((7 - i) * a0 + i * a1) / 7;
      end else begin
         for (int i = 1; i <= 4; i++) apal[i + 1] = ((5 - i) * a0 + i * a1) / 5;
         apal[6] = 0;
         apal[7] = 255;
      end

      for (int py = 0; py < 4; py++) begin
         for (int px = 0; px < 4; px++) begin
            x = blk_col * 4 + px;
            y = blk_row * 4 + py;
            if (x < w && y < h) begin
               loc = py * 4 + px;
               cc = cidx[loc * 2 +: 2];
               av = cfg_dxt5 ? apal[aidx[loc * 3 +: 3]] : cpal[cc][3];
               pix.pixel_x = 14'(x);
               pix.pixel_y = 14'(y);
               pix.red = 8'(cpal[cc][0]);
               pix.green = 8'(cpal[cc][1]);
               pix.blue = 8'(cpal[cc][2]);
               pix.alpha = 8'(av);
               pix.block_done = 1'b0;
               pix.image_done = 1'b0;
               block_pixels.push_back(pix);
            end
         end
      end
      // the top-left pixel of a block is always inside the image
      block_pixels[block_pixels.size() - 1].block_done = 1'b1;
      block_pixels[block_pixels.size() - 1].image_done = last_blk;

      blk_col++;
      if (blk_col >= bw) begin
         blk_col = 0;
         blk_row++;
         if (blk_row >= bh) blk_row = 0;
      end
   endfunction

   // ---------------------------------------------------------------- drivers

   // APB write: setup, access, then an idle gap with psel low so back-to-back calls never collide
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      reg_writes++;
      case (idx)
         REG_FORMAT: cfg_dxt5 = value[0];
         REG_WIDTH:  cfg_width = value[14:0];
         REG_HEIGHT: cfg_height = value[14:0];
         default: ;
      endcase
      // any real register write restarts the image
      if (idx != REG_SPARE) begin
         blk_col = 0;
         blk_row = 0;
      end
      @(posedge clock);
   endtask

   // waits for every expected pixel, then lets the pipeline go quiet
   task automatic settle_pipeline();
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one block transaction; push stays high when the next block follows without a gap
   task automatic send_block(input bcd_req_type blk, input bit typed,
                             input bcd_rsp_type typed_pixel);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= blk;
      do @(posedge clock); while (req_full);
      decode_block(blk);
      if (typed) begin
         pending_pixels.push_back(typed_pixel);
      end else begin
         foreach (block_pixels[i]) pending_pixels.push_back(block_pixels[i]);
      end
      blocks_sent++;
   endtask

   // ---------------------------------------------------------------- stimulus helpers

   function automatic void add_block(input logic [63:0] alpha_w, input logic [63:0] color_w);
      stim_row_type r;
      r.kind = ROW_BLOCK;
      r.reg_idx = REG_FORMAT;
      r.reg_val = '0;
      r.blk.alpha_word = alpha_w;
      r.blk.color_word = color_w;
      r.typed = 1'b0;
      r.pixel = '0;
      directed_rows.push_back(r);
   endfunction

   // only valid while the image is 1x1: the single pixel sits at 0,0 and closes the image
   function automatic void add_typed(input logic [63:0] alpha_w, input logic [63:0] color_w,
                                     input logic [7:0] r8, input logic [7:0] g8,
                                     input logic [7:0] b8, input logic [7:0] a8);
      add_block(alpha_w, color_w);
      directed_rows[$].typed = 1'b1;
      directed_rows[$].pixel = '{pixel_x: 14'd0, pixel_y: 14'd0, red: r8, green: g8,
                                 blue: b8, alpha: a8, block_done: 1'b1, image_done: 1'b1};
   endfunction

   function automatic void add_reg(input logic [1:0] idx, input logic [31:0] value);
      stim_row_type r;
      r.kind = ROW_CSR;
      r.reg_idx = idx;
      r.reg_val = value;
      r.blk = '0;
      r.typed = 1'b0;
      r.pixel = '0;
      directed_rows.push_back(r);
   endfunction

   function automatic bcd_req_type random_block();
      bcd_req_type b;
      logic [15:0] tc;
      logic [7:0]  ta;
      b.color_word = {$urandom, $urandom};
      b.alpha_word = {$urandom, $urandom};
      // bias endpoint order: equal, c0 > c1, c0 < c1, or as drawn
      case ($urandom_range(0, 3))
         0: b.color_word[31:16] = b.color_word[15:0];
         1: if (b.color_word[15:0] < b.color_word[31:16]) begin
               tc = b.color_word[15:0];
               b.color_word[15:0] = b.color_word[31:16];
               b.color_word[31:16] = tc;
            end
         2: if (b.color_word[15:0] > b.color_word[31:16]) begin
               tc = b.color_word[15:0];
               b.color_word[15:0] = b.color_word[31:16];
               b.color_word[31:16] = tc;
            end
         default: ;
      endcase
      case ($urandom_range(0, 3))
         0: b.alpha_word[15:8] = b.alpha_word[7:0];
         1: if (b.alpha_word[7:0] < b.alpha_word[15:8]) begin
               ta = b.alpha_word[7:0];
               b.alpha_word[7:0] = b.alpha_word[15:8];
               b.alpha_word[15:8] = ta;
            end
         2: if (b.alpha_word[7:0] > b.alpha_word[15:8]) begin
               ta = b.alpha_word[7:0];
               b.alpha_word[7:0] = b.alpha_word[15:8];
               b.alpha_word[15:8] = ta;
            end
         default: ;
      endcase
      return b;
   endfunction

   // mostly small images; now and then zero, the maximum, oversize or a full 32-bit value
   function automatic logic [31:0] pick_dim();
      case ($urandom_range(0, 15))
         0: return 32'd0;
         1: return MAX_DIM;
         2: return 32'd16385;
         3: return 32'h0000_7FFF;
         4: return $urandom;
         default: return $urandom_range(1, 24);
      endcase
   endfunction

   function automatic void build_directed_rows();
      // reset state: DXT1, 1x1 image; alpha half is don't-care here
      add_typed(64'd0, 64'd0, 8'd0, 8'd0, 8'd0, 8'd255);
      add_typed('1, 64'h0000_0000_0000_FFFF, 8'd255, 8'd255, 8'd255, 8'd255);
      add_typed(64'd0, 64'h0000_0003_0000_0000, 8'd0, 8'd0, 8'd0, 8'd0);        // transparent
      add_typed(64'd0, 64'h0000_0002_FFFF_0000, 8'd127, 8'd127, 8'd127, 8'd255); // midpoint
      add_typed(64'd0, 64'h0000_0002_0000_FFFF, 8'd170, 8'd170, 8'd170, 8'd255); // 2/3 point
      add_typed(64'd0, 64'h0000_0003_0000_FFFF, 8'd85, 8'd85, 8'd85, 8'd255);    // 1/3 point
      add_typed(64'd0, 64'h0000_0000_0000_F800, 8'd255, 8'd0, 8'd0, 8'd255);
      add_typed('1, '1, 8'd0, 8'd0, 8'd0, 8'd0);  // equal endpoints, index 3
      // DXT5, still 1x1
      add_reg(REG_FORMAT, 32'd1);
      add_typed(64'd0, 64'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      add_typed(64'h0000_0000_0007_0000, '1, 8'd255, 8'd255, 8'd255, 8'd255); // fixed 255
      add_typed(64'h0000_0000_0006_FF00, 64'd0, 8'd0, 8'd0, 8'd0, 8'd0);        // fixed 0
      add_typed(64'h0000_0000_0002_00FF, 64'd0, 8'd0, 8'd0, 8'd0, 8'd218);      // sevenths
      // c0 < c1 still takes the thirds under DXT5
      add_typed('1, 64'h0000_0003_FFFF_0000, 8'd170, 8'd170, 8'd170, 8'd255);
      // zero dimensions behave as 1
      add_reg(REG_WIDTH, 32'd0);
      add_reg(REG_HEIGHT, 32'd0);
      add_block({$urandom, $urandom}, {$urandom, $urandom});
      // 5x6: right and bottom blocks are partial, fifth block wraps to a new image
      add_reg(REG_WIDTH, 32'd5);
      add_reg(REG_HEIGHT, 32'd6);
      repeat (5) add_block({$urandom, $urandom}, {$urandom, $urandom});
      // mode change restarts the image; a write past the last register does not
      add_reg(REG_FORMAT, 32'd0);
      repeat (2) add_block({$urandom, $urandom}, {$urandom, $urandom});
      add_reg(REG_SPARE, 32'hFFFF_FFFF);
      repeat (2) add_block({$urandom, $urandom}, {$urandom, $urandom});
      // oversize width clamps to the maximum
      add_reg(REG_WIDTH, 32'hFFFF_FFFF);
      add_reg(REG_HEIGHT, MAX_DIM);
      repeat (2) add_block({$urandom, $urandom}, {$urandom, $urandom});
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_pixel(input bcd_rsp_type got);
      bcd_rsp_type want;
      if (pending_pixels.size() == 0) begin
         $error("pixel transaction with none expected: x %0d y %0d", got.pixel_x, got.pixel_y);
         mismatch_count++;
         return;
      end
      want = pending_pixels.pop_front();
      compare_field("pixel_x", want.pixel_x, got.pixel_x);
      compare_field("pixel_y", want.pixel_y, got.pixel_y);
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("alpha", want.alpha, got.alpha);
      compare_field("block_done", want.block_done, got.block_done);
      compare_field("image_done", want.image_done, got.image_done);
      pixels_checked++;
      if (want.image_done) images_seen++;
   endtask

   // pixel side: random pop gaps, plus the one long hold-off on request
   initial begin : pixel_sink
      int unsigned hold;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (long_hold != 0) begin
            hold = long_hold;
            long_hold = 0;
         end else begin
            hold = idle_on ? $urandom_range(0, 3) : 0;
         end
         if (hold != 0) begin
            rsp_pop <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         check_pixel(rsp_data);
      end
   end

   // watchdog: ends the run after too many cycles with no transaction on either side
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet = 0;
         else quiet++;
      end
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------- main sequence

   initial begin : stimulus
      int unsigned nitems, phase_no;
      bcd_rsp_type no_pixel;

      no_pixel = '0;
      build_directed_rows();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            req_push <= 1'b0;
            settle_pipeline();
            write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
         end else begin
            send_block(directed_rows[i].blk, directed_rows[i].typed, directed_rows[i].pixel);
         end
      end

      phase_no = 0;
      while (blocks_sent < TOTAL_BLOCKS) begin
         req_push <= 1'b0;
         settle_pipeline();
         // now and then keep the settings so the block position runs on across the pause
         if (phase_no == 0 || $urandom_range(0, 3) != 0) begin
            write_reg(REG_FORMAT, $urandom_range(0, 1));
            write_reg(REG_WIDTH, pick_dim());
            write_reg(REG_HEIGHT, pick_dim());
         end
         idle_on = ($urandom_range(0, 3) != 0);
         nitems = $urandom_range(4, 30);
         if (phase_no == 1) begin
            // backpressure phase: pixel side stalls while blocks keep coming back to back
            idle_on = 1'b0;
            nitems = 24;
            long_hold = LONG_HOLD;
         end
         if (nitems > TOTAL_BLOCKS - blocks_sent) nitems = TOTAL_BLOCKS - blocks_sent;
         repeat (nitems) send_block(random_block(), 1'b0, no_pixel);
         phase_no++;
      end

      req_push <= 1'b0;
      settle_pipeline();

      $display("covered %0d blocks in %0d random phases, %0d register writes",
               blocks_sent, phase_no, reg_writes);
      $display("checked %0d pixels including %0d image ends, %0d mismatches",
               pixels_checked, images_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/bcd_pkg.sv
rtl/core/bcd_front.sv
rtl/core/bcd_queue.sv
rtl/core/bcd_back.sv
rtl/core/bc1_bc3_block_decoder_unit.sv
verif/bc1_bc3_block_decoder_unit_test.sv
